>>> hw/rtl/vpbc_pkg.sv
// Shared types, widths and codes for the vertex projection and backface cull block.
package vpbc_pkg;

  // Slot count default for the projected point store
  localparam int MAX_VERTICES_DEF = 32;

  // Field widths
  localparam int TRIG_W    = 16;
  localparam int DIST_W    = 10;
  localparam int COORD_W   = 8;
  localparam int IDX_W     = 5;
  localparam int SCR_W     = 16;
  localparam int COLOR_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Datapath widths
  localparam int Q_FRAC  = 14;               // Q2.14 trig fraction bits
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 17;
  localparam int ACC_W   = MUL_A_W + MUL_B_W;
  localparam int ROT_W   = 25;               // yaw-rotated x and z, Q.14
  localparam int CAMY_W  = 28;               // camera y and z after >>14
  localparam int DEPTH_W = 28;               // saturated depth, unsigned
  localparam int MAG_W   = 38;               // |coord * focal|
  localparam int DVD_W   = MAG_W + 4;        // *16 plus rounding bias
  localparam int QUO_W   = DVD_W - Q_FRAC;   // depth >= 2^14 bounds the quotient
  localparam int SUM_W   = QUO_W + 2;        // center term plus signed quotient
  localparam int DIFF_W  = SCR_W + 1;

  localparam logic [DEPTH_W-1:0] MIN_DEPTH = DEPTH_W'(1) << Q_FRAC;

  // Register reset values
  localparam logic [TRIG_W-1:0] COS_YAW_RST   = 16'd16384;
  localparam logic [TRIG_W-1:0] SIN_YAW_RST   = 16'd0;
  localparam logic [TRIG_W-1:0] COS_PITCH_RST = 16'd16384;
  localparam logic [TRIG_W-1:0] SIN_PITCH_RST = 16'd0;
  localparam logic [DIST_W-1:0] CAM_DIST_RST  = 10'd200;
  localparam logic [DIST_W-1:0] FOCAL_RST     = 10'd200;
  localparam logic [DIST_W-1:0] CENTER_X_RST  = 10'd120;
  localparam logic [DIST_W-1:0] CENTER_Y_RST  = 10'd120;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_YAW   = 3'd0,
    CFG_SIN_YAW   = 3'd1,
    CFG_COS_PITCH = 3'd2,
    CFG_SIN_PITCH = 3'd3,
    CFG_CAM_DIST  = 3'd4,
    CFG_FOCAL     = 3'd5,
    CFG_CENTER_X  = 3'd6,
    CFG_CENTER_Y  = 3'd7
  } cfg_index_t;

  // Operation codes
  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_FACE   = 1'b1;

  // Sequencer states
  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_MAC      = 11'b000_0000_0010,
    ST_DIV_INIT = 11'b000_0000_0100,
    ST_DIV      = 11'b000_0000_1000,
    ST_DIV_DONE = 11'b000_0001_0000,
    ST_FACE_RD  = 11'b000_0010_0000,
    ST_DIFF     = 11'b000_0100_0000,
    ST_CROSS0   = 11'b000_1000_0000,
    ST_CROSS1   = 11'b001_0000_0000,
    ST_TEST     = 11'b010_0000_0000,
    ST_SPARE    = 11'b100_0000_0000
  } state_t;

  // Multiply-accumulate steps of a vertex
  typedef enum logic [3:0] {
    MS_X_COS  = 4'd0,   // x*cos_yaw
    MS_Z_SIN  = 4'd1,   // - z*sin_yaw      -> rx
    MS_X_SIN  = 4'd2,   // x*sin_yaw
    MS_Z_COS  = 4'd3,   // + z*cos_yaw      -> rz
    MS_Y_CP   = 4'd4,   // ry*cos_pitch
    MS_Z_SP   = 4'd5,   // - rz*sin_pitch   -> camera y
    MS_Y_SP   = 4'd6,   // ry*sin_pitch
    MS_Z_CP   = 4'd7,   // + rz*cos_pitch   -> depth
    MS_RX_FL  = 4'd8,   // rx*focal
    MS_CY_FL  = 4'd9,   // camy*focal
    MS_LAST   = 4'd10   // capture only
  } mac_step_t;

  // Input word
  typedef struct packed {
    logic                      operation;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [COORD_W-1:0] model_x;
    logic signed [COORD_W-1:0] model_y;
    logic signed [COORD_W-1:0] model_z;
    logic [IDX_W-1:0]          corner_a;
    logic [IDX_W-1:0]          corner_b;
    logic [IDX_W-1:0]          corner_c;
    logic [IDX_W-1:0]          corner_d;
    logic [COLOR_W-1:0]        face_color;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [SCR_W-1:0] screen_ax;
    logic signed [SCR_W-1:0] screen_ay;
    logic signed [SCR_W-1:0] screen_bx;
    logic signed [SCR_W-1:0] screen_by;
    logic signed [SCR_W-1:0] screen_cx;
    logic signed [SCR_W-1:0] screen_cy;
    logic signed [SCR_W-1:0] screen_dx;
    logic signed [SCR_W-1:0] screen_dy;
    logic [COLOR_W-1:0]      quad_color;
  } out_word_t;

endpackage

>>> hw/rtl/vertex_project_backface_cull_top.sv
// Vertex projection to screen space and quad backface cull, one shared MAC and divider.
//
//  channel | ports                          | direction | moves
//  --------+--------------------------------+-----------+-------------------------------
//  in      | in_valid, in_ready, in_data    | in        | vertex or face word
//  out     | out_valid, out_ready, out_data | out       | visible quad word
//  cfg     | cfg_we, cfg_index, cfg_wdata   | in        | register write, no wait
//
// A vertex word holds the block for 11 steps on the shared 32x17 MAC, then two passes
// (setup, 28 quotient bits, finish) through the restoring divider.
// A face word holds it for the four reads through the single read port of the point store,
// then differences, two MAC steps and the sign test, plus any wait on a full output register.
// in_ready is high only when the sequencer is idle. Reset is synchronous; the point store
// is not cleared, and a slot read before it is written returns unknown data.
module vertex_project_backface_cull_top #(
  parameter int MAX_VERTICES = vpbc_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  vpbc_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vpbc_pkg::out_word_t               out_data,
  input  logic                              cfg_we,
  input  logic [vpbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vpbc_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int DCNT_W = $clog2(vpbc_pkg::QUO_W);
  localparam int MEM_W  = 2 * vpbc_pkg::SCR_W;
  localparam int SW     = vpbc_pkg::SCR_W;
  localparam int AW     = vpbc_pkg::ACC_W;
  localparam int QF     = vpbc_pkg::Q_FRAC;
  localparam int DW     = vpbc_pkg::DEPTH_W;
  localparam int QW     = vpbc_pkg::QUO_W;

  // Configuration registers
  logic signed [vpbc_pkg::TRIG_W-1:0] cos_yaw_r, sin_yaw_r, cos_pitch_r, sin_pitch_r;
  logic [vpbc_pkg::DIST_W-1:0]        cam_dist_r, focal_r, center_x_r, center_y_r;

  // Sequencer
  vpbc_pkg::state_t    state_r, state_nxt;
  vpbc_pkg::mac_step_t mstep_r, mstep_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [2:0]          fcnt_r, fcnt_nxt;
  logic                which_r, which_nxt;

  // Held input word
  vpbc_pkg::in_word_t in_r;

  // Shared MAC
  logic                               mac_en, mac_clr, mac_sub;
  logic signed [vpbc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [vpbc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [AW-1:0]               prod, acc_r, acc_nxt, acc_abs;

  // Vertex intermediates
  logic signed [vpbc_pkg::ROT_W-1:0]  rx_r, rz_r;
  logic signed [vpbc_pkg::CAMY_W-1:0] camy_r, camz;
  logic signed [DW:0]                 dep_sum;
  logic [DW-1:0]                      depth_r;
  logic                               negx_r, negy_r;
  logic [vpbc_pkg::MAG_W-1:0]         magx_r, magy_r;
  logic signed [SW-1:0]               sx_r;

  // Divider
  logic [DW-1:0]              rem_r;
  logic [QW-1:0]              quo_r;
  logic [vpbc_pkg::DVD_W-1:0] dvd;
  logic [DW:0]                div_sh, div_trial;
  logic                       neg_eff;
  logic signed [vpbc_pkg::SUM_W-1:0] q_term, c_term, scr_sum;
  logic signed [SW-1:0]       scr_sat;

  // Point store
  logic [MEM_W-1:0]  mem [MAX_VERTICES];
  logic              mem_we, mem_re, idx_ok;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [vpbc_pkg::IDX_W-1:0] rd_idx;
  logic [MEM_W-1:0]  rd_data_r;
  logic              rd_ok_r;
  logic [1:0]        cap_idx;

  // Face datapath
  logic signed [SW-1:0]               px_r [4];
  logic signed [SW-1:0]               py_r [4];
  logic signed [vpbc_pkg::DIFF_W-1:0] d1_r, d2_r, d3_r, d4_r;
  logic                               visible, out_load;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  vpbc_pkg::out_word_t out_r;

  function automatic logic signed [SW-1:0] sat_scr(input logic signed [vpbc_pkg::SUM_W-1:0] v);
    logic signed [vpbc_pkg::SUM_W-1:0] hi, lo;
    hi = vpbc_pkg::SUM_W'(32767);
    lo = -vpbc_pkg::SUM_W'(32768);
    if (v > hi) begin
      return 16'sh7fff;
    end else if (v < lo) begin
      return 16'sh8000;
    end
    return v[SW-1:0];
  endfunction

  assign in_ready  = (state_r == vpbc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_yaw_r   <= vpbc_pkg::COS_YAW_RST;
      sin_yaw_r   <= vpbc_pkg::SIN_YAW_RST;
      cos_pitch_r <= vpbc_pkg::COS_PITCH_RST;
      sin_pitch_r <= vpbc_pkg::SIN_PITCH_RST;
      cam_dist_r  <= vpbc_pkg::CAM_DIST_RST;
      focal_r     <= vpbc_pkg::FOCAL_RST;
      center_x_r  <= vpbc_pkg::CENTER_X_RST;
      center_y_r  <= vpbc_pkg::CENTER_Y_RST;
    end else if (cfg_we) begin
      case (vpbc_pkg::cfg_index_t'(cfg_index))
        vpbc_pkg::CFG_COS_YAW:   cos_yaw_r   <= cfg_wdata;
        vpbc_pkg::CFG_SIN_YAW:   sin_yaw_r   <= cfg_wdata;
        vpbc_pkg::CFG_COS_PITCH: cos_pitch_r <= cfg_wdata;
        vpbc_pkg::CFG_SIN_PITCH: sin_pitch_r <= cfg_wdata;
        vpbc_pkg::CFG_CAM_DIST:  cam_dist_r  <= cfg_wdata[vpbc_pkg::DIST_W-1:0];
        vpbc_pkg::CFG_FOCAL:     focal_r     <= cfg_wdata[vpbc_pkg::DIST_W-1:0];
        vpbc_pkg::CFG_CENTER_X:  center_x_r  <= cfg_wdata[vpbc_pkg::DIST_W-1:0];
        vpbc_pkg::CFG_CENTER_Y:  center_y_r  <= cfg_wdata[vpbc_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // MAC operand select
  always_comb begin
    mac_en  = 1'b0;
    mac_clr = 1'b0;
    mac_sub = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_r)
      vpbc_pkg::ST_MAC: begin
        mac_en = 1'b1;
        case (mstep_r)
          vpbc_pkg::MS_X_COS: begin
            mac_clr = 1'b1;
            mul_a   = {{24{in_r.model_x[7]}}, in_r.model_x};
            mul_b   = {cos_yaw_r[15], cos_yaw_r};
          end
          vpbc_pkg::MS_Z_SIN: begin
            mac_sub = 1'b1;
            mul_a   = {{24{in_r.model_z[7]}}, in_r.model_z};
            mul_b   = {sin_yaw_r[15], sin_yaw_r};
          end
          vpbc_pkg::MS_X_SIN: begin
            mac_clr = 1'b1;
            mul_a   = {{24{in_r.model_x[7]}}, in_r.model_x};
            mul_b   = {sin_yaw_r[15], sin_yaw_r};
          end
          vpbc_pkg::MS_Z_COS: begin
            mul_a = {{24{in_r.model_z[7]}}, in_r.model_z};
            mul_b = {cos_yaw_r[15], cos_yaw_r};
          end
          vpbc_pkg::MS_Y_CP: begin
            mac_clr = 1'b1;
            mul_a   = {{10{in_r.model_y[7]}}, in_r.model_y, 14'b0};
            mul_b   = {cos_pitch_r[15], cos_pitch_r};
          end
          vpbc_pkg::MS_Z_SP: begin
            mac_sub = 1'b1;
            mul_a   = {{7{rz_r[24]}}, rz_r};
            mul_b   = {sin_pitch_r[15], sin_pitch_r};
          end
          vpbc_pkg::MS_Y_SP: begin
            mac_clr = 1'b1;
            mul_a   = {{10{in_r.model_y[7]}}, in_r.model_y, 14'b0};
            mul_b   = {sin_pitch_r[15], sin_pitch_r};
          end
          vpbc_pkg::MS_Z_CP: begin
            mul_a = {{7{rz_r[24]}}, rz_r};
            mul_b = {cos_pitch_r[15], cos_pitch_r};
          end
          vpbc_pkg::MS_RX_FL: begin
            mac_clr = 1'b1;
            mul_a   = {{7{rx_r[24]}}, rx_r};
            mul_b   = {7'b0, focal_r};
          end
          vpbc_pkg::MS_CY_FL: begin
            mac_clr = 1'b1;
            mul_a   = {{4{camy_r[27]}}, camy_r};
            mul_b   = {7'b0, focal_r};
          end
          default: mac_en = 1'b0;
        endcase
      end
      vpbc_pkg::ST_CROSS0: begin
        mac_en  = 1'b1;
        mac_clr = 1'b1;
        mul_a   = {{15{d1_r[16]}}, d1_r};
        mul_b   = d2_r;
      end
      vpbc_pkg::ST_CROSS1: begin
        mac_en  = 1'b1;
        mac_sub = 1'b1;
        mul_a   = {{15{d3_r[16]}}, d3_r};
        mul_b   = d4_r;
      end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign acc_nxt = (mac_clr ? '0 : acc_r) + (mac_sub ? -prod : prod);
  assign acc_abs = acc_r[AW-1] ? -acc_r : acc_r;

  // Depth from camera z, clamped to one model unit
  assign camz    = acc_r[vpbc_pkg::CAMY_W+QF-1:QF];
  assign dep_sum = {camz[vpbc_pkg::CAMY_W-1], camz} + {5'b0, cam_dist_r, 14'b0};

  // Divider setup and one quotient bit per cycle
  assign dvd       = {(which_r ? magy_r : magx_r), 4'b0} + vpbc_pkg::DVD_W'(depth_r >> 1);
  assign div_sh    = {rem_r, quo_r[QW-1]};
  assign div_trial = div_sh - {1'b0, depth_r};

  // Signed rounded quotient onto the screen center
  assign neg_eff = which_r ? ~negy_r : negx_r;
  assign q_term  = neg_eff ? -{2'b0, quo_r} : {2'b0, quo_r};
  assign c_term  = {16'b0, (which_r ? center_y_r : center_x_r), 4'b0};
  assign scr_sum = c_term + q_term;
  assign scr_sat = sat_scr(scr_sum);

  // Point store addressing
  assign idx_ok  = (32'(in_r.vertex_index) < MAX_VERTICES);
  assign wr_addr = ADDR_W'(in_r.vertex_index);
  assign mem_we  = (state_r == vpbc_pkg::ST_DIV_DONE) && which_r && idx_ok;
  assign mem_re  = (state_r == vpbc_pkg::ST_FACE_RD) && !fcnt_r[2];
  assign rd_addr = ADDR_W'(rd_idx);
  assign cap_idx = 2'(fcnt_r - 3'd1);

  always_comb begin
    case (fcnt_r[1:0])
      2'd0:    rd_idx = in_r.corner_a;
      2'd1:    rd_idx = in_r.corner_b;
      2'd2:    rd_idx = in_r.corner_c;
      default: rd_idx = in_r.corner_d;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {sx_r, scr_sat};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
      rd_ok_r   <= (32'(rd_idx) < MAX_VERTICES);
    end
  end

  // Cull test and output load
  assign visible  = !acc_r[AW-1] && (acc_r != '0);
  assign out_load = (state_r == vpbc_pkg::ST_TEST) && visible && (!out_valid_r || out_ready);
  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    mstep_nxt = mstep_r;
    dcnt_nxt  = dcnt_r;
    fcnt_nxt  = fcnt_r;
    which_nxt = which_r;
    case (state_r)
      vpbc_pkg::ST_IDLE: begin
        if (in_valid) begin
          mstep_nxt = vpbc_pkg::MS_X_COS;
          fcnt_nxt  = 3'd0;
          which_nxt = 1'b0;
          state_nxt = (in_data.operation == vpbc_pkg::OP_FACE) ?
                      vpbc_pkg::ST_FACE_RD : vpbc_pkg::ST_MAC;
        end
      end
      vpbc_pkg::ST_MAC: begin
        if (mstep_r == vpbc_pkg::MS_LAST) begin
          state_nxt = vpbc_pkg::ST_DIV_INIT;
        end else begin
          mstep_nxt = vpbc_pkg::mac_step_t'(mstep_r + 4'd1);
        end
      end
      vpbc_pkg::ST_DIV_INIT: begin
        dcnt_nxt  = '0;
        state_nxt = vpbc_pkg::ST_DIV;
      end
      vpbc_pkg::ST_DIV: begin
        if (dcnt_r == DCNT_W'(QW - 1)) begin
          state_nxt = vpbc_pkg::ST_DIV_DONE;
        end else begin
          dcnt_nxt = dcnt_r + DCNT_W'(1);
        end
      end
      vpbc_pkg::ST_DIV_DONE: begin
        if (!which_r) begin
          which_nxt = 1'b1;
          state_nxt = vpbc_pkg::ST_DIV_INIT;
        end else begin
          state_nxt = vpbc_pkg::ST_IDLE;
        end
      end
      vpbc_pkg::ST_FACE_RD: begin
        if (fcnt_r[2]) begin
          state_nxt = vpbc_pkg::ST_DIFF;
        end else begin
          fcnt_nxt = fcnt_r + 3'd1;
        end
      end
      vpbc_pkg::ST_DIFF:   state_nxt = vpbc_pkg::ST_CROSS0;
      vpbc_pkg::ST_CROSS0: state_nxt = vpbc_pkg::ST_CROSS1;
      vpbc_pkg::ST_CROSS1: state_nxt = vpbc_pkg::ST_TEST;
      vpbc_pkg::ST_TEST: begin
        if (!visible || out_load) begin
          state_nxt = vpbc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vpbc_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vpbc_pkg::ST_IDLE;
      mstep_r     <= vpbc_pkg::MS_X_COS;
      dcnt_r      <= '0;
      fcnt_r      <= '0;
      which_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mstep_r     <= mstep_nxt;
      dcnt_r      <= dcnt_nxt;
      fcnt_r      <= fcnt_nxt;
      which_r     <= which_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (mac_en) begin
      acc_r <= acc_nxt;
    end

    // captures are made in the MAC step after the one that produced them
    if (state_r == vpbc_pkg::ST_MAC) begin
      case (mstep_r)
        vpbc_pkg::MS_X_SIN: rx_r   <= acc_r[vpbc_pkg::ROT_W-1:0];
        vpbc_pkg::MS_Y_CP:  rz_r   <= acc_r[vpbc_pkg::ROT_W-1:0];
        vpbc_pkg::MS_Y_SP:  camy_r <= camz;
        vpbc_pkg::MS_RX_FL: begin
          if (dep_sum[DW] || (dep_sum[DW-1:0] < vpbc_pkg::MIN_DEPTH)) begin
            depth_r <= vpbc_pkg::MIN_DEPTH;
          end else begin
            depth_r <= dep_sum[DW-1:0];
          end
        end
        vpbc_pkg::MS_CY_FL: begin
          negx_r <= acc_r[AW-1];
          magx_r <= acc_abs[vpbc_pkg::MAG_W-1:0];
        end
        vpbc_pkg::MS_LAST: begin
          negy_r <= acc_r[AW-1];
          magy_r <= acc_abs[vpbc_pkg::MAG_W-1:0];
        end
        default: ;
      endcase
    end

    // restoring divide; top dividend bits sit below the divisor at start
    if (state_r == vpbc_pkg::ST_DIV_INIT) begin
      rem_r <= DW'(dvd[vpbc_pkg::DVD_W-1:QW]);
      quo_r <= dvd[QW-1:0];
    end else if (state_r == vpbc_pkg::ST_DIV) begin
      if (!div_trial[DW]) begin
        rem_r <= div_trial[DW-1:0];
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= div_sh[DW-1:0];
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
    end

    if ((state_r == vpbc_pkg::ST_DIV_DONE) && !which_r) begin
      sx_r <= scr_sat;
    end

    // corner capture; slots beyond the store read as the origin
    if ((state_r == vpbc_pkg::ST_FACE_RD) && (fcnt_r != 3'd0)) begin
      px_r[cap_idx] <= rd_ok_r ? rd_data_r[MEM_W-1:SW] : '0;
      py_r[cap_idx] <= rd_ok_r ? rd_data_r[SW-1:0] : '0;
    end

    if (state_r == vpbc_pkg::ST_DIFF) begin
      d1_r <= {px_r[1][SW-1], px_r[1]} - {px_r[0][SW-1], px_r[0]};
      d2_r <= {py_r[2][SW-1], py_r[2]} - {py_r[0][SW-1], py_r[0]};
      d3_r <= {py_r[1][SW-1], py_r[1]} - {py_r[0][SW-1], py_r[0]};
      d4_r <= {px_r[2][SW-1], px_r[2]} - {px_r[0][SW-1], px_r[0]};
    end

    if (out_load) begin
      out_r.screen_ax  <= px_r[0];
      out_r.screen_ay  <= py_r[0];
      out_r.screen_bx  <= px_r[1];
      out_r.screen_by  <= py_r[1];
      out_r.screen_cx  <= px_r[2];
      out_r.screen_cy  <= py_r[2];
      out_r.screen_dx  <= px_r[3];
      out_r.screen_dy  <= py_r[3];
      out_r.quad_color <= in_r.face_color;
    end
  end

`ifndef ASSERT_OFF
  // a result only ever appears out of the cull test
  a_out_from_test: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == vpbc_pkg::ST_TEST))
    else $error("result raised outside the cull test");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vpbc_pkg::ST_DIV) |-> (rem_r < depth_r))
    else $error("divider remainder not below depth");

  // depth is clamped before any divide starts
  a_depth_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vpbc_pkg::ST_DIV_INIT) |-> (depth_r >= vpbc_pkg::MIN_DEPTH))
    else $error("depth below one model unit at divide");
`endif

endmodule
